// File: rtl/core/qfts_pkg.sv
// ----------------------------------------------------------------------------
// qfts_pkg
// Shared types and constants for the two-stack queue: opcodes, status codes,
// controller states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package qfts_pkg;

  // Default sizes
  localparam int unsigned DEPTH_DEFAULT      = 8;
  localparam int unsigned WORD_WIDTH_DEFAULT = 32;

  // Fixed field widths on the stream ports
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_READ,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/qfts_ram.sv
// ----------------------------------------------------------------------------
// qfts_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data, valid the cycle after a read. Holds one stack.
// ----------------------------------------------------------------------------
`default_nettype none

module qfts_ram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/queue_from_two_stacks.sv
// ----------------------------------------------------------------------------
// queue_from_two_stacks
// First-in first-out queue built from an incoming and an outgoing stack,
// each held in its own synchronous RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time and every request gives exactly one result
// item. An enqueue with room writes the incoming RAM on acceptance and then
// passes through S_RESP; a dequeue or peek from a non-empty outgoing stack
// passes through S_READ (for the RAM read) and then S_RESP. When the
// outgoing stack is empty and must be refilled, S_MOVE comes first: the
// incoming RAM read port moves one entry per cycle, pipelined into the
// outgoing RAM write port, and the request goes on once that pipeline has
// drained. A full incoming stack with a non-empty outgoing stack drops the
// enqueue with status full. An empty queue answers with data all ones (within
// WORD_WIDTH) and status empty. The result waits in an output register, so a
// stalled consumer holds only the final step. Stack contents are not cleared
// at reset; only entries below the counts are ever read.
`default_nettype none

module queue_from_two_stacks #(
  parameter int unsigned DEPTH      = qfts_pkg::DEPTH_DEFAULT,
  parameter int unsigned WORD_WIDTH = qfts_pkg::WORD_WIDTH_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [qfts_pkg::DATA_W-1:0]   s_axis_tdata,   // [31:0] value
  input  wire logic [qfts_pkg::OP_W-1:0]     s_axis_tuser,   // [1:0] opcode
  // Result items
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [qfts_pkg::DATA_W-1:0]   m_axis_tdata,   // [31:0] data
  output logic      [qfts_pkg::ST_W-1:0]     m_axis_tuser    // [1:0] status
);

  import qfts_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [DATA_W-1:0] EMPTY_DATA = DATA_W'({WORD_WIDTH{1'b1}});

  // Control state
  state_e              state_q, state_d;
  logic [CW-1:0]       in_cnt_q, in_cnt_d;
  logic [CW-1:0]       out_cnt_q, out_cnt_d;
  logic                pend_q, pend_d;
  logic                ovalid_q, ovalid_d;

  // Payload registers
  logic [OP_W-1:0]       op_q, op_d;
  logic [WORD_WIDTH-1:0] word_q, word_d;
  logic [DATA_W-1:0]     res_data_q, res_data_d;
  status_e               res_st_q, res_st_d;
  logic [DATA_W-1:0]     odata_q, odata_d;
  status_e               ost_q, ost_d;

  // RAM ports
  logic                  in_we, in_re, out_we, out_re;
  logic [AW-1:0]         in_waddr, in_raddr, out_waddr, out_raddr;
  logic [WORD_WIDTH-1:0] in_wdata, in_rdata, out_wdata, out_rdata;

  logic                  load_out;

  qfts_ram #(
    .Depth (DEPTH),
    .Width (WORD_WIDTH)
  ) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (in_we),
    .waddr_i (in_waddr),
    .wdata_i (in_wdata),
    .re_i    (in_re),
    .raddr_i (in_raddr),
    .rdata_o (in_rdata)
  );

  qfts_ram #(
    .Depth (DEPTH),
    .Width (WORD_WIDTH)
  ) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (out_we),
    .waddr_i (out_waddr),
    .wdata_i (out_wdata),
    .re_i    (out_re),
    .raddr_i (out_raddr),
    .rdata_o (out_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ost_q;

  // Next state, RAM controls and results
  always_comb begin
    state_d    = state_q;
    in_cnt_d   = in_cnt_q;
    out_cnt_d  = out_cnt_q;
    pend_d     = pend_q;
    op_d       = op_q;
    word_d     = word_q;
    res_data_d = res_data_q;
    res_st_d   = res_st_q;
    odata_d    = odata_q;
    ost_d      = ost_q;
    load_out   = 1'b0;

    in_we     = 1'b0;
    in_waddr  = AW'(in_cnt_q);
    in_wdata  = word_q;
    in_re     = 1'b0;
    in_raddr  = AW'(in_cnt_q - 1'b1);
    out_we    = 1'b0;
    out_waddr = AW'(out_cnt_q);
    out_wdata = in_rdata;
    out_re    = 1'b0;
    out_raddr = AW'(out_cnt_q - 1'b1);

    unique case (state_q)
      // Accept a request and take the fast path where possible
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d       = s_axis_tuser;
          word_d     = WORD_WIDTH'(s_axis_tdata);
          res_data_d = '0;
          res_st_d   = ST_OK;
          if (s_axis_tuser == OP_ENQ) begin
            if (in_cnt_q < FULL_CNT) begin
              in_we    = 1'b1;
              in_wdata = WORD_WIDTH'(s_axis_tdata);
              in_cnt_d = in_cnt_q + 1'b1;
              state_d  = S_RESP;
            end else if (out_cnt_q != '0) begin
              res_st_d = ST_FULL;
              state_d  = S_RESP;
            end else begin
              pend_d  = 1'b0;
              state_d = S_MOVE;
            end
          end else if (s_axis_tuser == OP_DEQ || s_axis_tuser == OP_PEEK) begin
            if (out_cnt_q != '0) begin
              out_re  = 1'b1;
              state_d = S_READ;
            end else if (in_cnt_q != '0) begin
              pend_d  = 1'b0;
              state_d = S_MOVE;
            end else begin
              res_data_d = EMPTY_DATA;
              res_st_d   = ST_EMPTY;
              state_d    = S_RESP;
            end
          end else begin
            state_d = S_RESP;
          end
        end
      end

      // Pop incoming, push outgoing: one entry per cycle, read then write
      S_MOVE: begin
        if (pend_q) begin
          out_we    = 1'b1;
          out_cnt_d = out_cnt_q + 1'b1;
        end
        if (in_cnt_q != '0) begin
          in_re    = 1'b1;
          in_cnt_d = in_cnt_q - 1'b1;
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (in_cnt_q == '0 && !pend_q) begin
          if (op_q == OP_ENQ) begin
            in_we    = 1'b1;
            in_cnt_d = in_cnt_q + 1'b1;
            state_d  = S_RESP;
          end else begin
            out_re  = 1'b1;
            state_d = S_READ;
          end
        end
      end

      // Top of outgoing stack is on the read port
      S_READ: begin
        res_data_d = DATA_W'(out_rdata);
        res_st_d   = ST_OK;
        if (op_q == OP_DEQ) begin
          out_cnt_d = out_cnt_q - 1'b1;
        end
        state_d = S_RESP;
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!ovalid_q || m_axis_tready) begin
          load_out = 1'b1;
          odata_d  = res_data_q;
          ost_d    = res_st_q;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    ovalid_d = load_out | (ovalid_q & ~m_axis_tready);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      pend_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      pend_q    <= pend_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    word_q     <= word_d;
    res_data_q <= res_data_d;
    res_st_q   <= res_st_d;
    odata_q    <= odata_d;
    ost_q      <= ost_d;
  end

endmodule

`default_nettype wire

// File: bench/queue_from_two_stacks_tb.sv
// ----------------------------------------------------------------------------
// queue_from_two_stacks_tb
// Self-checking bench for the two-stack queue. A directed opening walks the
// empty, move-across and full cases, then random enqueue, dequeue and peek
// items follow with shifting enqueue bias. A behavioral model of the two
// stacks predicts every result item; the monitor compares each returned item
// with the oldest prediction. Both stream sides idle at random in phases.
// ----------------------------------------------------------------------------
`default_nettype none

module queue_from_two_stacks_tb;

  import qfts_pkg::*;

  localparam int unsigned STACK_DEPTH = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_REQUESTS = 550;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    op_e         op;
    logic [31:0] value;
  } request_t;

  typedef struct {
    logic [31:0] data;
    status_e     status;
  } queue_result_t;

  // Clock, reset and stream signals
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata = '0;   // [31:0] value
  logic [OP_W-1:0]     s_axis_tuser = '0;   // [1:0] opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DATA_W-1:0]   m_axis_tdata;        // [31:0] data
  logic [ST_W-1:0]     m_axis_tuser;        // [1:0] status

  // Bench state
  request_t      pending_requests[$];
  queue_result_t expected_results[$];
  int unsigned   total_requests = 0;
  int unsigned   sent_count = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   idle_phase;
  int unsigned   sender_idle_pct;
  int unsigned   receiver_idle_pct;

  // Model of the two stacks
  logic [31:0]   inbound_stack[STACK_DEPTH];
  logic [31:0]   outbound_stack[STACK_DEPTH];
  int unsigned   inbound_count = 0;
  int unsigned   outbound_count = 0;

  queue_from_two_stacks #(
    .DEPTH      (DEPTH_DEFAULT),
    .WORD_WIDTH (WORD_WIDTH_DEFAULT)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Pop every inbound entry onto the outbound stack, reversing their order
  function automatic void move_inbound_across();
    while (inbound_count > 0 && outbound_count < STACK_DEPTH) begin
      inbound_count--;
      outbound_stack[outbound_count] = inbound_stack[inbound_count];
      outbound_count++;
    end
  endfunction

  // Apply one request to the model and return the result item it gives
  function automatic queue_result_t predict_queue_result(op_e op, logic [31:0] value);
    queue_result_t res;
    res.data = '0;
    res.status = ST_OK;
    case (op)
      OP_ENQ: begin
        if (inbound_count >= STACK_DEPTH) begin
          if (outbound_count != 0) res.status = ST_FULL;
          else move_inbound_across();
        end
        if (res.status == ST_OK && inbound_count < STACK_DEPTH) begin
          inbound_stack[inbound_count] = value;
          inbound_count++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (outbound_count == 0) move_inbound_across();
        if (outbound_count == 0) begin
          res.data = '1;
          res.status = ST_EMPTY;
        end else begin
          res.data = outbound_stack[outbound_count-1];
          if (op == OP_DEQ) outbound_count--;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic add_request(op_e op, logic [31:0] value);
    request_t req;
    req.op = op;
    req.value = value;
    pending_requests.push_back(req);
  endtask

  // Word with a bias toward corner words: signed extremes, zero, all ones, alternating bits
  function automatic logic [31:0] pick_word();
    logic [31:0] words[6];
    words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
              32'hAAAA_AAAA, 32'h5555_5555};
    if ($urandom_range(0, 7) == 0) return words[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // Idle rates per phase: sender light first, then receiver light, then none
  always_comb begin
    idle_phase = (total_requests == 0) ? 0 : (sent_count * 3) / total_requests;
    case (idle_phase)
      0: begin
        sender_idle_pct = 19;
        receiver_idle_pct = 49;
      end
      1: begin
        sender_idle_pct = 49;
        receiver_idle_pct = 19;
      end
      default: begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
    endcase
  end

  // Drive request items from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_requests.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        request_t req;
        req = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req.value;
        s_axis_tuser <= req.op;
        sent_count <= sent_count + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(
          predict_queue_result(op_e'(s_axis_tuser), s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: data=%h status=%0d",
                     m_axis_tdata, m_axis_tuser);
        end else begin
          queue_result_t exp_res;
          exp_res = expected_results.pop_front();
          if (m_axis_tdata !== exp_res.data || m_axis_tuser !== exp_res.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected data=%h status=%0d, got data=%h status=%0d",
                       exp_res.data, exp_res.status, m_axis_tdata, m_axis_tuser);
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned enq_pct;
    int unsigned pct_choices[4];
    pct_choices = '{25, 50, 75, 90};

    // Empty queue on both read kinds
    add_request(OP_DEQ, 32'hFFFF_FFFF);
    add_request(OP_PEEK, 32'h0000_0000);
    // Fill the inbound stack with extreme words
    add_request(OP_ENQ, 32'h8000_0000);
    add_request(OP_ENQ, 32'h7FFF_FFFF);
    add_request(OP_ENQ, 32'h0000_0000);
    add_request(OP_ENQ, 32'hFFFF_FFFF);
    add_request(OP_ENQ, 32'hAAAA_AAAA);
    add_request(OP_ENQ, 32'h5555_5555);
    add_request(OP_ENQ, 32'h0000_0001);
    add_request(OP_ENQ, 32'hFFFF_FFFE);
    // Inbound full, outbound empty: move across, then push
    add_request(OP_ENQ, 32'h1234_5678);
    for (int i = 0; i < 7; i++) add_request(OP_ENQ, 32'hC000_0000 + i);
    // Inbound full, outbound holds entries: dropped
    add_request(OP_ENQ, 32'hDEAD_BEEF);
    add_request(OP_PEEK, 32'h5555_5555);
    add_request(OP_DEQ, 32'hAAAA_AAAA);
    add_request(OP_ENQ, 32'h0F0F_0F0F);
    add_request(OP_PEEK, 32'h0);
    add_request(OP_DEQ, 32'h0);

    // Random part in blocks with varying enqueue bias
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 40 == 0) enq_pct = pct_choices[$urandom_range(0, 3)];
      if ($urandom_range(0, 99) < enq_pct) add_request(OP_ENQ, pick_word());
      else if ($urandom_range(0, 2) != 0) add_request(OP_DEQ, pick_word());
      else add_request(OP_PEEK, pick_word());
    end
    total_requests = pending_requests.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all requests accepted and all results returned
    do begin
      @(negedge clk_i);
    end while (pending_requests.size() != 0 || s_axis_tvalid ||
               expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/qfts_pkg.sv
rtl/core/qfts_ram.sv
rtl/core/queue_from_two_stacks.sv
bench/queue_from_two_stacks_tb.sv
